/* sv/tfts_pkg.sv */
// types and constants for the title format token scanner
// request payload structs, token kind and style codes, byte classes
// no dependencies
package tfts_pkg;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       final_byte;
    } tfts_in_t;

    typedef struct packed {
        logic [2:0]  token_kind;
        logic [3:0]  token_style;
        logic [15:0] span_start;
        logic [15:0] span_end;
        logic        is_closed;
        logic        last_in_run;
    } tfts_out_t;

    localparam logic [2:0] K_TEXT     = 3'd0;
    localparam logic [2:0] K_FIELD    = 3'd1;
    localparam logic [2:0] K_FUNCTION = 3'd2;
    localparam logic [2:0] K_QUOTE    = 3'd3;
    localparam logic [2:0] K_COMMENT  = 3'd4;
    localparam logic [2:0] K_SYMBOL   = 3'd5;
    localparam logic [2:0] K_NUMBER   = 3'd6;

    localparam logic [3:0] S_TEXT     = 4'd0;
    localparam logic [3:0] S_COMMENT  = 4'd1;
    localparam logic [3:0] S_QUOTED   = 4'd2;
    localparam logic [3:0] S_FIELD    = 4'd3;
    localparam logic [3:0] S_FUNCTION = 4'd4;
    localparam logic [3:0] S_COND     = 4'd5;
    localparam logic [3:0] S_OPER     = 4'd6;
    localparam logic [3:0] S_NUMBER   = 4'd7;
    localparam logic [3:0] S_ERROR    = 4'd8;

    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_DEL     = 8'h7f;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_VTAB    = 8'h0b;
    localparam logic [7:0] CH_FF      = 8'h0c;
    localparam logic [7:0] CH_LF      = 8'h0a;
    localparam logic [7:0] CH_CR      = 8'h0d;
    localparam logic [7:0] CH_SLASH   = 8'h2f;
    localparam logic [7:0] CH_QUOTE   = 8'h27;
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_DOLLAR  = 8'h24;
    localparam logic [7:0] CH_LBRACK  = 8'h5b;
    localparam logic [7:0] CH_RBRACK  = 8'h5d;
    localparam logic [7:0] CH_LPAREN  = 8'h28;
    localparam logic [7:0] CH_RPAREN  = 8'h29;
    localparam logic [7:0] CH_COMMA   = 8'h2c;
    localparam logic [7:0] CH_LT      = 8'h3c;
    localparam logic [7:0] CH_GT      = 8'h3e;
    localparam logic [7:0] CH_0       = 8'h30;
    localparam logic [7:0] CH_9       = 8'h39;
    localparam logic [7:0] CH_UA      = 8'h41;
    localparam logic [7:0] CH_UZ      = 8'h5a;
    localparam logic [7:0] CH_LA      = 8'h61;
    localparam logic [7:0] CH_LZ      = 8'h7a;
    localparam logic [7:0] CH_UNDER   = 8'h5f;

    function automatic logic is_newline(input logic [7:0] b);
        return (b == CH_CR) || (b == CH_LF);
    endfunction

    function automatic logic is_indent(input logic [7:0] b);
        return (b == CH_SPACE) || (b == CH_TAB) || (b == CH_VTAB) || (b == CH_FF);
    endfunction

    function automatic logic is_control(input logic [7:0] b);
        return (b < CH_SPACE) || (b == CH_DEL);
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        return (b >= CH_0) && (b <= CH_9);
    endfunction

    function automatic logic is_func_byte(input logic [7:0] b);
        return ((b >= CH_UA) && (b <= CH_UZ)) || ((b >= CH_LA) && (b <= CH_LZ))
            || is_digit(b) || (b == CH_UNDER) || b[7];
    endfunction

endpackage

/* sv/title_format_token_scanner_top.sv */
// title format token scanner: byte stream in, token spans out, depends on tfts_pkg
// scan state machine plus a four-entry result queue
// a result is queued when its closing request is taken; out_valid is set from the queue count
// throughput: one byte per cycle; a byte may queue two results, output drains one per cycle
// while out_ready is high, and in_ready drops while fewer than two queue entries are free
// reset: asynchronous active-low, scanner idle at line indent, position 0, queue empty
module title_format_token_scanner_top
    import tfts_pkg::*;
#(
    parameter int POSITION_BITS = 16
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  tfts_in_t  in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output tfts_out_t out_data
);

    typedef enum logic [3:0] {
        MD_IDLE,
        MD_SLASH,
        MD_COMMENT,
        MD_QFIRST,
        MD_QBODY,
        MD_QSAW,
        MD_FEMPTY,
        MD_FNAME,
        MD_FUNC,
        MD_NUMBER
    } mode_t;

    localparam int QDEPTH = 4;

    mode_t                    mode_reg, mode_next;
    logic                     indent_reg, indent_next;
    logic [POSITION_BITS-1:0] start_reg, start_next;
    logic [POSITION_BITS-1:0] pos_reg, pos_next;
    logic                     ferr_reg, ferr_next;

    tfts_out_t                q_reg [QDEPTH];
    logic [1:0]               wr_reg, rd_reg;
    logic [2:0]               cnt_reg, cnt_next;

    tfts_out_t                em [2];
    logic [1:0]               em_cnt;
    logic                     acc, pop;
    logic [7:0]               b;
    logic [POSITION_BITS-1:0] nxt;
    logic                     do_start;

    function automatic tfts_out_t make_tok(input logic [2:0] k, input logic [3:0] s,
                                           input logic [POSITION_BITS-1:0] st,
                                           input logic [POSITION_BITS-1:0] en,
                                           input logic cl);
        tfts_out_t t;
        t.token_kind  = k;
        t.token_style = s;
        t.span_start  = 16'(st);
        t.span_end    = 16'(en);
        t.is_closed   = cl;
        t.last_in_run = 1'b0;
        return t;
    endfunction

    assign in_ready  = (cnt_reg <= 3'(QDEPTH - 2));
    assign acc       = in_valid && in_ready;
    assign out_valid = (cnt_reg != 3'd0);
    assign out_data  = q_reg[rd_reg];
    assign pop       = out_valid && out_ready;
    assign b         = in_data.text_byte;
    assign nxt       = (pos_reg == '1) ? pos_reg : pos_reg + POSITION_BITS'(1);

    always_comb
    begin
        mode_next   = mode_reg;
        start_next  = start_reg;
        ferr_next   = ferr_reg;
        indent_next = indent_reg;
        pos_next    = nxt;
        em[0]       = make_tok(K_TEXT, S_TEXT, pos_reg, nxt, 1'b0);
        em[1]       = em[0];
        em_cnt      = 2'd0;
        do_start    = 1'b0;

        case (mode_reg)
            MD_SLASH:
            begin
                if (b == CH_SLASH)
                    mode_next = MD_COMMENT;
                else
                begin
                    em[0]    = make_tok(K_TEXT, S_TEXT, start_reg, pos_reg, 1'b0);
                    em_cnt   = 2'd1;
                    do_start = 1'b1;
                end
            end
            MD_COMMENT:
            begin
                if (is_newline(b))
                begin
                    em[0]    = make_tok(K_COMMENT, S_COMMENT, start_reg, pos_reg, 1'b0);
                    em_cnt   = 2'd1;
                    do_start = 1'b1;
                end
            end
            MD_QFIRST:
            begin
                if (b == CH_QUOTE)
                begin
                    em[0]     = make_tok(K_QUOTE, S_QUOTED, start_reg, nxt, 1'b1);
                    em_cnt    = 2'd1;
                    mode_next = MD_IDLE;
                end
                else
                    mode_next = MD_QBODY;
            end
            MD_QBODY:
            begin
                if (b == CH_QUOTE)
                    mode_next = MD_QSAW;
            end
            MD_QSAW:
            begin
                if (b == CH_QUOTE)
                    mode_next = MD_QBODY;
                else
                begin
                    em[0]    = make_tok(K_QUOTE, S_QUOTED, start_reg, pos_reg, 1'b1);
                    em_cnt   = 2'd1;
                    do_start = 1'b1;
                end
            end
            MD_FEMPTY, MD_FNAME:
            begin
                if (b == CH_PERCENT)
                begin
                    // empty name or a control byte inside gives error style
                    em[0] = make_tok(K_FIELD,
                                     ((mode_reg == MD_FEMPTY) || ferr_reg) ? S_ERROR : S_FIELD,
                                     start_reg, nxt, 1'b1);
                    em_cnt    = 2'd1;
                    mode_next = MD_IDLE;
                end
                else if (is_newline(b))
                begin
                    em[0]    = make_tok(K_FIELD, S_ERROR, start_reg, pos_reg, 1'b0);
                    em_cnt   = 2'd1;
                    do_start = 1'b1;
                end
                else
                begin
                    if (is_control(b))
                        ferr_next = 1'b1;
                    mode_next = MD_FNAME;
                end
            end
            MD_FUNC:
            begin
                if (!is_func_byte(b))
                begin
                    em[0]    = make_tok(K_FUNCTION, S_FUNCTION, start_reg, pos_reg, 1'b0);
                    em_cnt   = 2'd1;
                    do_start = 1'b1;
                end
            end
            MD_NUMBER:
            begin
                if (!is_digit(b))
                begin
                    em[0]    = make_tok(K_NUMBER, S_NUMBER, start_reg, pos_reg, 1'b0);
                    em_cnt   = 2'd1;
                    do_start = 1'b1;
                end
            end
            default:
                do_start = 1'b1;
        endcase

        // byte scanned as the first byte of a new token
        if (do_start)
        begin
            start_next = pos_reg;
            mode_next  = MD_IDLE;
            if (indent_reg && (b == CH_SLASH))
                mode_next = MD_SLASH;
            else if (b == CH_QUOTE)
                mode_next = MD_QFIRST;
            else if (b == CH_PERCENT)
            begin
                mode_next = MD_FEMPTY;
                ferr_next = 1'b0;
            end
            else if (b == CH_DOLLAR)
                mode_next = MD_FUNC;
            else if (is_digit(b))
                mode_next = MD_NUMBER;
            else
            begin
                if ((b == CH_LBRACK) || (b == CH_RBRACK))
                    em[em_cnt[0]] = make_tok(K_SYMBOL, S_COND, pos_reg, nxt, 1'b0);
                else if ((b == CH_LPAREN) || (b == CH_RPAREN) || (b == CH_COMMA)
                         || (b == CH_LT) || (b == CH_GT))
                    em[em_cnt[0]] = make_tok(K_SYMBOL, S_OPER, pos_reg, nxt, 1'b0);
                else
                    em[em_cnt[0]] = make_tok(K_TEXT, S_TEXT, pos_reg, nxt, 1'b0);
                em_cnt = em_cnt + 2'd1;
            end
        end

        if (is_newline(b))
            indent_next = 1'b1;
        else if (!is_indent(b))
            indent_next = 1'b0;

        // end of text flushes whatever token is still open
        if (in_data.final_byte)
        begin
            if ((mode_next != MD_IDLE) && (em_cnt != 2'd2))
            begin
                case (mode_next)
                    MD_SLASH:
                        em[em_cnt[0]] = make_tok(K_TEXT, S_TEXT, start_next, nxt, 1'b0);
                    MD_COMMENT:
                        em[em_cnt[0]] = make_tok(K_COMMENT, S_COMMENT, start_next, nxt, 1'b0);
                    MD_QFIRST, MD_QBODY:
                        em[em_cnt[0]] = make_tok(K_QUOTE, S_QUOTED, start_next, nxt, 1'b0);
                    MD_QSAW:
                        em[em_cnt[0]] = make_tok(K_QUOTE, S_QUOTED, start_next, nxt, 1'b1);
                    MD_FEMPTY, MD_FNAME:
                        em[em_cnt[0]] = make_tok(K_FIELD, ferr_next ? S_ERROR : S_FIELD,
                                                 start_next, nxt, 1'b0);
                    MD_FUNC:
                        em[em_cnt[0]] = make_tok(K_FUNCTION, S_FUNCTION, start_next, nxt,
                                                 1'b0);
                    default:
                        em[em_cnt[0]] = make_tok(K_NUMBER, S_NUMBER, start_next, nxt, 1'b0);
                endcase
                em_cnt = em_cnt + 2'd1;
            end
            mode_next   = MD_IDLE;
            indent_next = 1'b1;
            start_next  = '0;
            pos_next    = '0;
            ferr_next   = 1'b0;
        end

        if (em_cnt == 2'd2)
            em[1].last_in_run = 1'b1;
        else
            em[0].last_in_run = 1'b1;

        cnt_next = cnt_reg - {2'd0, pop};
        if (acc)
            cnt_next = cnt_next + {1'b0, em_cnt};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MD_IDLE;
            indent_reg <= 1'b1;
            start_reg  <= '0;
            pos_reg    <= '0;
            ferr_reg   <= 1'b0;
            wr_reg     <= 2'd0;
            rd_reg     <= 2'd0;
            cnt_reg    <= 3'd0;
        end
        else
        begin
            if (acc)
            begin
                mode_reg   <= mode_next;
                indent_reg <= indent_next;
                start_reg  <= start_next;
                pos_reg    <= pos_next;
                ferr_reg   <= ferr_next;
                wr_reg     <= wr_reg + em_cnt;
            end
            if (pop)
                rd_reg <= rd_reg + 2'd1;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc && (em_cnt != 2'd0))
            q_reg[wr_reg] <= em[0];
        if (acc && (em_cnt == 2'd2))
            q_reg[wr_reg + 2'd1] <= em[1];
    end

`ifndef SYNTHESIS
    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= 3'(QDEPTH))
        else $error("result queue overfilled");

    a_final_resets: assert property (@(posedge clk) disable iff (!rst_n)
        (acc && in_data.final_byte) |=> (pos_reg == '0) && (mode_reg == MD_IDLE)
                                        && indent_reg)
        else $error("scanner not back at start of text after final byte");

    a_pos_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        (acc && !in_data.final_byte) |=> (pos_reg >= $past(pos_reg)))
        else $error("byte position went backwards inside a text");

    a_single_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == 3'd1) |-> out_data.last_in_run)
        else $error("lone queued result is not the last of its byte");
`endif

endmodule

/* dv/tb_title_format_token_scanner_top.sv */
// testbench for title_format_token_scanner_top: directed and random script text in,
// token spans checked against a local scan predictor, span by span
// depends on tfts_pkg and the scanner rtl
module tb_title_format_token_scanner_top
    import tfts_pkg::*;
();

    localparam logic [15:0] POS_MAX     = 16'hffff;
    localparam int          RUN_LIMIT   = 20_000_000;
    localparam int          HOLD_CYCLES = 60;
    localparam int          SLOW_PCT    = 73;
    localparam int          LIGHT_PCT   = 6;
    localparam int          RANDOM_BYTES = 1400;

    typedef enum logic [3:0] {
        SC_IDLE,
        SC_SLASH,
        SC_COMMENT,
        SC_QFIRST,
        SC_QBODY,
        SC_QSAW,
        SC_FEMPTY,
        SC_FNAME,
        SC_FUNC,
        SC_NUMBER
    } scan_state_t;

    logic      clk      = 1'b0;
    logic      rst_n    = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_ready;
    tfts_in_t  in_data  = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    tfts_out_t out_data;

    tfts_in_t  script_bytes[$];
    tfts_out_t due_spans[$];

    int sent_cnt      = 0;
    int err_cnt       = 0;
    int recv_slow_end = 0;
    int send_slow_end = 0;
    int hold_at       = 0;
    int hold_left     = 0;
    bit hold_done     = 1'b0;

    // predictor state
    scan_state_t sc_mode      = SC_IDLE;
    logic        sc_indent    = 1'b1;
    logic [15:0] sc_tok_start = '0;
    logic [15:0] sc_pos       = '0;
    logic        sc_field_err = 1'b0;
    tfts_out_t   tok_buf[2];
    int          tok_n;

    title_format_token_scanner_top #(
        .POSITION_BITS(16)
    ) uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data (out_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic logic byte_is_eol(input logic [7:0] b);
        return b == CH_LF || b == CH_CR;
    endfunction

    function automatic logic byte_is_blank(input logic [7:0] b);
        return b == CH_SPACE || b == CH_TAB || b == CH_VTAB || b == CH_FF;
    endfunction

    function automatic logic byte_is_ctrl(input logic [7:0] b);
        return b < CH_SPACE || b == CH_DEL;
    endfunction

    function automatic logic byte_is_digit(input logic [7:0] b);
        return b >= CH_0 && b <= CH_9;
    endfunction

    function automatic logic byte_is_name(input logic [7:0] b);
        logic [7:0] low;
        low = (b >= CH_UA && b <= CH_UZ) ? (b | 8'h20) : b;
        return (low >= CH_LA && low <= CH_LZ) || byte_is_digit(b) || b == CH_UNDER
            || b >= 8'h80;
    endfunction

    function automatic void add_token(input logic [2:0] kind, input logic [3:0] style,
                                      input logic [15:0] from_pos, input logic [15:0] to_pos,
                                      input logic closed);
        if (tok_n < 2)
        begin
            tok_buf[tok_n].token_kind  = kind;
            tok_buf[tok_n].token_style = style;
            tok_buf[tok_n].span_start  = from_pos;
            tok_buf[tok_n].span_end    = to_pos;
            tok_buf[tok_n].is_closed   = closed;
            tok_buf[tok_n].last_in_run = 1'b0;
            tok_n++;
        end
    endfunction

    function automatic logic [3:0] field_style();
        return sc_field_err ? S_ERROR : S_FIELD;
    endfunction

    // byte b begins a new token
    function automatic void open_token(input logic [7:0] b, input logic [15:0] here,
                                       input logic [15:0] after);
        sc_mode = SC_IDLE;
        sc_tok_start = here;
        if (sc_indent && b == CH_SLASH)
            sc_mode = SC_SLASH;
        else if (b == CH_QUOTE)
            sc_mode = SC_QFIRST;
        else if (b == CH_PERCENT)
        begin
            sc_mode = SC_FEMPTY;
            sc_field_err = 1'b0;
        end
        else if (b == CH_DOLLAR)
            sc_mode = SC_FUNC;
        else if (b == CH_LBRACK || b == CH_RBRACK)
            add_token(K_SYMBOL, S_COND, here, after, 1'b0);
        else if (b == CH_LPAREN || b == CH_RPAREN || b == CH_COMMA || b == CH_LT || b == CH_GT)
            add_token(K_SYMBOL, S_OPER, here, after, 1'b0);
        else if (byte_is_digit(b))
            sc_mode = SC_NUMBER;
        else
            add_token(K_TEXT, S_TEXT, here, after, 1'b0);
    endfunction

    function automatic void close_open_token(input logic [15:0] to_pos);
        case (sc_mode)
            SC_SLASH:            add_token(K_TEXT, S_TEXT, sc_tok_start, to_pos, 1'b0);
            SC_COMMENT:          add_token(K_COMMENT, S_COMMENT, sc_tok_start, to_pos, 1'b0);
            SC_QFIRST, SC_QBODY: add_token(K_QUOTE, S_QUOTED, sc_tok_start, to_pos, 1'b0);
            SC_QSAW:             add_token(K_QUOTE, S_QUOTED, sc_tok_start, to_pos, 1'b1);
            SC_FEMPTY, SC_FNAME: add_token(K_FIELD, field_style(), sc_tok_start, to_pos, 1'b0);
            SC_FUNC:             add_token(K_FUNCTION, S_FUNCTION, sc_tok_start, to_pos, 1'b0);
            SC_NUMBER:           add_token(K_NUMBER, S_NUMBER, sc_tok_start, to_pos, 1'b0);
            default:             ;
        endcase
        sc_mode = SC_IDLE;
    endfunction

    // advance the scan by one byte and queue the spans it closes
    function automatic void scan_byte(input logic [7:0] b, input logic fin);
        logic [15:0] here;
        logic [15:0] after;
        logic [15:0] s;
        tfts_out_t   t;
        here  = sc_pos;
        after = (sc_pos == POS_MAX) ? sc_pos : sc_pos + 16'd1;
        s     = sc_tok_start;
        tok_n = 0;
        case (sc_mode)
            SC_SLASH:
            begin
                if (b == CH_SLASH)
                    sc_mode = SC_COMMENT;
                else
                begin
                    add_token(K_TEXT, S_TEXT, s, here, 1'b0);
                    open_token(b, here, after);
                end
            end
            SC_COMMENT:
            begin
                if (byte_is_eol(b))
                begin
                    add_token(K_COMMENT, S_COMMENT, s, here, 1'b0);
                    open_token(b, here, after);
                end
            end
            SC_QFIRST:
            begin
                if (b == CH_QUOTE)
                begin
                    add_token(K_QUOTE, S_QUOTED, s, after, 1'b1);
                    sc_mode = SC_IDLE;
                end
                else
                    sc_mode = SC_QBODY;
            end
            SC_QBODY:
            begin
                if (b == CH_QUOTE)
                    sc_mode = SC_QSAW;
            end
            SC_QSAW:
            begin
                // a second quote byte is an escape and keeps the quote open
                if (b == CH_QUOTE)
                    sc_mode = SC_QBODY;
                else
                begin
                    add_token(K_QUOTE, S_QUOTED, s, here, 1'b1);
                    open_token(b, here, after);
                end
            end
            SC_FEMPTY, SC_FNAME:
            begin
                if (b == CH_PERCENT)
                begin
                    add_token(K_FIELD, (sc_mode == SC_FEMPTY) ? S_ERROR : field_style(),
                              s, after, 1'b1);
                    sc_mode = SC_IDLE;
                end
                else if (byte_is_eol(b))
                begin
                    add_token(K_FIELD, S_ERROR, s, here, 1'b0);
                    open_token(b, here, after);
                end
                else
                begin
                    if (byte_is_ctrl(b))
                        sc_field_err = 1'b1;
                    sc_mode = SC_FNAME;
                end
            end
            SC_FUNC:
            begin
                if (!byte_is_name(b))
                begin
                    add_token(K_FUNCTION, S_FUNCTION, s, here, 1'b0);
                    open_token(b, here, after);
                end
            end
            SC_NUMBER:
            begin
                if (!byte_is_digit(b))
                begin
                    add_token(K_NUMBER, S_NUMBER, s, here, 1'b0);
                    open_token(b, here, after);
                end
            end
            default:
                open_token(b, here, after);
        endcase

        if (byte_is_eol(b))
            sc_indent = 1'b1;
        else if (!byte_is_blank(b))
            sc_indent = 1'b0;
        sc_pos = after;

        if (fin)
        begin
            close_open_token(after);
            sc_indent    = 1'b1;
            sc_tok_start = '0;
            sc_pos       = '0;
            sc_field_err = 1'b0;
        end

        for (int i = 0; i < tok_n; i++)
        begin
            t = tok_buf[i];
            t.last_in_run = (i == tok_n - 1);
            due_spans = {due_spans, t};
        end
    endfunction

    function automatic int sender_gap_pct();
        if (sent_cnt < recv_slow_end)
            return LIGHT_PCT;
        else if (sent_cnt < send_slow_end)
            return SLOW_PCT;
        return 0;
    endfunction

    function automatic int receiver_gap_pct();
        if (sent_cnt < recv_slow_end)
            return SLOW_PCT;
        else if (sent_cnt < send_slow_end)
            return LIGHT_PCT;
        return 0;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        err_cnt++;
    endtask

    task automatic check_field(input string name, input int got, input int want);
        if (got != want)
            report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
    endtask

    // stimulus building
    task automatic push_byte(input logic [7:0] b, input logic fin);
        tfts_in_t r;
        r.text_byte  = b;
        r.final_byte = fin;
        script_bytes = {script_bytes, r};
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++)
            push_byte(s[i], 1'b0);
    endtask

    task automatic end_text();
        script_bytes[script_bytes.size() - 1].final_byte = 1'b1;
    endtask

    function automatic logic [7:0] rand_eol();
        return ($urandom_range(1) != 0) ? CH_LF : CH_CR;
    endfunction

    function automatic logic [7:0] rand_blank();
        case ($urandom_range(3))
            0:       return CH_SPACE;
            1:       return CH_TAB;
            2:       return CH_VTAB;
            default: return CH_FF;
        endcase
    endfunction

    function automatic logic [7:0] rand_letter();
        logic [7:0] b;
        b = 8'($urandom_range(CH_LA, CH_LZ));
        return ($urandom_range(1) != 0) ? (b & 8'hdf) : b;
    endfunction

    function automatic logic [7:0] rand_name_byte();
        case ($urandom_range(3))
            0:       return rand_letter();
            1:       return 8'($urandom_range(CH_0, CH_9));
            2:       return CH_UNDER;
            default: return 8'($urandom_range(8'h80, 8'hff));
        endcase
    endfunction

    function automatic logic [7:0] rand_symbol();
        case ($urandom_range(6))
            0:       return CH_LBRACK;
            1:       return CH_RBRACK;
            2:       return CH_LPAREN;
            3:       return CH_RPAREN;
            4:       return CH_COMMA;
            5:       return CH_LT;
            default: return CH_GT;
        endcase
    endfunction

    task automatic append_random_token();
        logic [7:0] b;
        case ($urandom_range(11))
            0:
            begin
                // line comment, from a fresh line half of the time
                if ($urandom_range(1) != 0)
                    push_byte(rand_eol(), 1'b0);
                repeat ($urandom_range(2)) push_byte(rand_blank(), 1'b0);
                push_text("//");
                repeat ($urandom_range(5))
                begin
                    b = 8'($urandom_range(255));
                    push_byte(byte_is_eol(b) ? CH_UNDER : b, 1'b0);
                end
                if ($urandom_range(3) != 0)
                    push_byte(rand_eol(), 1'b0);
            end
            1:
            begin
                if ($urandom_range(1) != 0)
                    push_byte(rand_eol(), 1'b0);
                push_byte(CH_SLASH, 1'b0);
            end
            2:
            begin
                push_byte(CH_QUOTE, 1'b0);
                repeat ($urandom_range(4))
                begin
                    b = 8'($urandom_range(8'h20, 8'hff));
                    if ($urandom_range(3) == 0 || b == CH_QUOTE)
                    begin
                        push_byte(CH_QUOTE, 1'b0);
                        push_byte(CH_QUOTE, 1'b0);
                    end
                    else
                        push_byte(b, 1'b0);
                end
                if ($urandom_range(4) != 0)
                    push_byte(CH_QUOTE, 1'b0);
            end
            3:
            begin
                push_byte(CH_PERCENT, 1'b0);
                repeat ($urandom_range(4))
                begin
                    if ($urandom_range(6) == 0)
                        push_byte(($urandom_range(3) == 0) ? CH_DEL
                                  : 8'($urandom_range(8'h1f)), 1'b0);
                    else
                        push_byte(rand_letter(), 1'b0);
                end
                case ($urandom_range(6))
                    0:       push_byte(rand_eol(), 1'b0);
                    1:       ;
                    default: push_byte(CH_PERCENT, 1'b0);
                endcase
            end
            4:
            begin
                push_byte(CH_DOLLAR, 1'b0);
                repeat ($urandom_range(5)) push_byte(rand_name_byte(), 1'b0);
            end
            5:
                repeat ($urandom_range(1, 4)) push_byte(8'($urandom_range(CH_0, CH_9)), 1'b0);
            6:
                push_byte(rand_symbol(), 1'b0);
            7:
                push_byte(rand_eol(), 1'b0);
            8:
                push_byte(rand_blank(), 1'b0);
            9:
                push_byte(rand_letter(), 1'b0);
            default:
                push_byte(8'($urandom_range(255)), 1'b0);
        endcase
    endtask

    // sender: keeps a request up until it is taken
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data  <= '0;
        end
        else if (!in_valid || in_ready)
        begin
            if (script_bytes.size() != 0 && $urandom_range(99) >= sender_gap_pct())
            begin
                in_valid <= 1'b1;
                in_data  <= script_bytes.pop_front();
            end
            else
                in_valid <= 1'b0;
        end
    end

    // long receiver hold so the result queue fills and backs up the input
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
        else if (!hold_done && sent_cnt >= hold_at)
        begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
    end

    // receiver: check taken results, then predict from the request taken at this edge
    always @(posedge clk or negedge rst_n)
    begin : span_monitor
        tfts_out_t want_span;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            sent_cnt  <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (due_spans.size() == 0)
                    report_mismatch($sformatf("span %0d..%0d with nothing expected",
                                              out_data.span_start, out_data.span_end));
                else
                begin
                    want_span = due_spans.pop_front();
                    check_field("token_kind", int'(out_data.token_kind),
                                int'(want_span.token_kind));
                    check_field("token_style", int'(out_data.token_style),
                                int'(want_span.token_style));
                    check_field("span_start", int'(out_data.span_start),
                                int'(want_span.span_start));
                    check_field("span_end", int'(out_data.span_end),
                                int'(want_span.span_end));
                    check_field("is_closed", int'(out_data.is_closed),
                                int'(want_span.is_closed));
                    check_field("last_in_run", int'(out_data.last_in_run),
                                int'(want_span.last_in_run));
                end
            end
            if (in_valid && in_ready)
            begin
                scan_byte(in_data.text_byte, in_data.final_byte);
                sent_cnt <= sent_cnt + 1;
            end
            out_ready <= (hold_left == 0) && ($urandom_range(99) >= receiver_gap_pct());
        end
    end

    initial
    begin
        int rand_from;

        // lone slash as the final byte
        push_byte(CH_SLASH, 1'b1);
        // comment after indent, control byte inside, cut by newline
        push_text(" //");
        push_byte(8'h00, 1'b0);
        push_byte(CH_LF, 1'b0);
        // lone slash followed by text
        push_text("/a");
        // empty quote, then a quote with an escape closed at end of text
        push_text("''");
        push_text("'a''b'");
        end_text();
        // empty field name, control byte in a field, field cut by newline
        push_text("%%");
        push_byte(CH_PERCENT, 1'b0);
        push_byte(CH_DEL, 1'b0);
        push_byte(CH_PERCENT, 1'b0);
        push_text("%a");
        push_byte(CH_CR, 1'b0);
        push_byte(CH_DOLLAR, 1'b0);
        push_byte(8'hff, 1'b0);
        push_text("9(");
        end_text();

        rand_from = script_bytes.size();
        while (script_bytes.size() < rand_from + RANDOM_BYTES)
        begin
            repeat ($urandom_range(1, 10)) append_random_token();
            end_text();
        end
        recv_slow_end = rand_from + (script_bytes.size() - rand_from) / 2;
        send_slow_end = script_bytes.size();
        hold_at       = rand_from + 150;

        repeat (8) append_random_token();
        end_text();
        push_byte(CH_LPAREN, 1'b1);

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        while (script_bytes.size() != 0 || in_valid)
            @(posedge clk);
        while (due_spans.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        if (err_cnt == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        #(RUN_LIMIT);
        $display("timeout");
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

/* title_format_token_scanner_top.f */
sv/tfts_pkg.sv
sv/title_format_token_scanner_top.sv
dv/tb_title_format_token_scanner_top.sv
